### rtl/rgbc_pkg.sv
// Package for the 3x3 RGB convolution filter: widths, register map,
// reset values, lane control structs and a coefficient helper.
// No dependencies.
package rgbc_pkg;

   localparam int PIX_W       = 8;
   localparam int PIX3_W      = 3 * PIX_W;
   localparam int COEF_BITS   = 8;
   localparam int KERNEL_SIZE = 3;
   localparam int KTAPS       = KERNEL_SIZE * KERNEL_SIZE;
   localparam int KREG_W      = KERNEL_SIZE * COEF_BITS;
   localparam int DIV_W       = 10;
   localparam int WCFG_W      = 11;
   localparam int HCFG_W      = 13;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam logic [KREG_W-1:0] RST_KTOP    = KREG_W'(0);
   localparam logic [KREG_W-1:0] RST_KMID    = KREG_W'(65536);
   localparam logic [KREG_W-1:0] RST_KBOT    = KREG_W'(0);
   localparam logic [DIV_W-1:0]  RST_DIVISOR = DIV_W'(1);
   localparam logic [PIX_W-1:0]  RST_MAXVAL  = PIX_W'(255);
   localparam logic [WCFG_W-1:0] RST_WIDTH   = WCFG_W'(640);
   localparam logic [HCFG_W-1:0] RST_HEIGHT  = HCFG_W'(480);

   // product, row sum and total widths inside a lane
   localparam int PROD_W = PIX_W + COEF_BITS + 1;
   localparam int ROWS_W = PROD_W + 2;
   localparam int SUM_W  = ROWS_W + 2;
   localparam int MAG_W  = SUM_W - 1;

   typedef enum logic [2:0] {
      REG_KTOP    = 3'd0,
      REG_KMID    = 3'd1,
      REG_KBOT    = 3'd2,
      REG_DIVISOR = 3'd3,
      REG_MAXVAL  = 3'd4,
      REG_WIDTH   = 3'd5,
      REG_HEIGHT  = 3'd6,
      REG_NONE    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] divisor;
      logic [PIX_W-1:0] max_value;
   } lane_cmd_type;

   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] result;
   } lane_stat_type;

   function automatic logic [COEF_BITS-1:0] coef_at(input logic [KREG_W-1:0] kreg,
                                                     input int idx);
      return kreg[idx*COEF_BITS +: COEF_BITS];
   endfunction

endpackage

### rtl/rgbc_req_if.sv
// Input pixel channel: valid/ready handshake with action and RGB payload.
// Depends on rgbc_pkg.
interface rgbc_req_if import rgbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [PIX_W-1:0] in_red;
   logic [PIX_W-1:0] in_green;
   logic [PIX_W-1:0] in_blue;

   modport source (output valid, action, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

### rtl/rgbc_rsp_if.sv
// Output pixel channel: valid/ready handshake with RGB and flag payload.
// Depends on rgbc_pkg.
interface rgbc_rsp_if import rgbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic             is_border;
   logic             frame_last;

   modport source (output valid, out_red, out_green, out_blue, is_border, frame_last,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, is_border, frame_last,
                   output ready);
endinterface

### rtl/rgbc_lane.sv
// One color lane: nine products, row sums, total, then a restoring divide
// and clamp to 0..255 / max value. Depends on rgbc_pkg.
module rgbc_lane import rgbc_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  lane_cmd_type                      cmd,
   input  logic [KTAPS-1:0][PIX_W-1:0]       pix_taps,
   input  logic [KTAPS-1:0][COEF_BITS-1:0]   coef_taps,
   output lane_stat_type                     stat
);

   typedef enum logic [2:0] {
      L_IDLE, L_ROW, L_TOT, L_SIGN, L_DIV, L_FIN
   } lane_state_type;

   localparam int STEP_W = $clog2(MAG_W + 1);

   lane_state_type            state_ff;
   logic signed [PROD_W-1:0]  prod_ff [KTAPS];
   logic signed [ROWS_W-1:0]  row_ff  [KERNEL_SIZE];
   logic signed [SUM_W-1:0]   sum_ff;
   logic [MAG_W-1:0]          dvd_ff;
   logic [MAG_W-1:0]          quo_ff;
   logic [DIV_W:0]            rem_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [DIV_W-1:0]          divisor_ff;
   logic [PIX_W-1:0]          maxv_ff;
   lane_stat_type             stat_ff;

   logic [DIV_W:0]            rem_sh;
   logic                      q_bit;

   always_comb begin
      rem_sh = {rem_ff[DIV_W-1:0], dvd_ff[MAG_W-1]};
      q_bit  = (rem_sh >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= L_IDLE;
         stat_ff     <= '0;
      end else begin
         stat_ff.done <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (cmd.start) begin
                  for (int i = 0; i < KTAPS; i++) begin
                     prod_ff[i] <= $signed({1'b0, pix_taps[i]}) * $signed(coef_taps[i]);
                  end
                  divisor_ff <= cmd.divisor;
                  maxv_ff    <= cmd.max_value;
                  state_ff   <= L_ROW;
               end
            end
            L_ROW: begin
               for (int r = 0; r < KERNEL_SIZE; r++) begin
                  row_ff[r] <= ROWS_W'(prod_ff[r*KERNEL_SIZE])
                             + ROWS_W'(prod_ff[r*KERNEL_SIZE+1])
                             + ROWS_W'(prod_ff[r*KERNEL_SIZE+2]);
               end
               state_ff <= L_TOT;
            end
            L_TOT: begin
               sum_ff   <= SUM_W'(row_ff[0]) + SUM_W'(row_ff[1]) + SUM_W'(row_ff[2]);
               state_ff <= L_SIGN;
            end
            L_SIGN: begin
               // a negative sum divides as zero, so it clamps to zero and all
               // lanes keep the same latency
               dvd_ff   <= sum_ff[SUM_W-1] ? '0 : sum_ff[MAG_W-1:0];
               quo_ff   <= '0;
               rem_ff   <= '0;
               step_ff  <= STEP_W'(MAG_W);
               state_ff <= L_DIV;
            end
            L_DIV: begin
               rem_ff  <= q_bit ? (rem_sh - {1'b0, divisor_ff}) : rem_sh;
               quo_ff  <= {quo_ff[MAG_W-2:0], q_bit};
               dvd_ff  <= {dvd_ff[MAG_W-2:0], 1'b0};
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == STEP_W'(1)) begin
                  state_ff <= L_FIN;
               end
            end
            L_FIN: begin
               stat_ff.result <= (quo_ff > MAG_W'(255)) ? maxv_ff : quo_ff[PIX_W-1:0];
               stat_ff.done   <= 1'b1;
               state_ff       <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign stat = stat_ff;

endmodule

### rtl/rgb_conv3x3_clamp_filter_top.sv
// Top level of the 3x3 RGB convolution filter: APB registers, line stores,
// window, frame counters, three rgbc_lane instances and the output stage.
// Depends on rgbc_pkg, rgbc_req_if, rgbc_rsp_if, rgbc_lane.
//
//   port      direction  handshake         carries
//   req_ch    in         valid/ready       action, in_red, in_green, in_blue
//   rsp_ch    out        valid/ready       out_red/green/blue, is_border, frame_last
//   csr_*     in         APB, pready=1     seven filter/frame registers
//
// One beat at a time: an ignored drain beat is only taken, a non-emitting beat
// passes the window step, a border beat the window and output steps, an interior
// pixel also the lanes' bit-serial divide. Line stores are one-read/one-write
// memories read into registers as a beat is taken. Synchronous active-high reset;
// no clearing pass. A width write recomputes the output row/column with a divide
// before the next beat is taken. A full output register stalls only the last step.
module rgb_conv3x3_clamp_filter_top import rgbc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   rgbc_req_if.sink              req_ch,
   rgbc_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WC_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int HC_W   = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W  = COL_W + ROW_W;
   localparam int HW_W   = WC_W + HC_W;
   localparam int WSTP_W = $clog2(CNT_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_WIN, ST_CALC, ST_OUT, ST_WDIV
   } top_state_type;

   // registers
   logic [KREG_W-1:0] ktop_ff, kmid_ff, kbot_ff;
   logic [DIV_W-1:0]  divisor_ff;
   logic [PIX_W-1:0]  maxv_ff;
   logic [WCFG_W-1:0] width_ff;
   logic [HCFG_W-1:0] height_ff;

   logic              csr_wr;
   reg_idx_type       csr_idx;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         REG_KTOP:    csr_prdata = CSR_DATA_W'(ktop_ff);
         REG_KMID:    csr_prdata = CSR_DATA_W'(kmid_ff);
         REG_KBOT:    csr_prdata = CSR_DATA_W'(kbot_ff);
         REG_DIVISOR: csr_prdata = CSR_DATA_W'(divisor_ff);
         REG_MAXVAL:  csr_prdata = CSR_DATA_W'(maxv_ff);
         REG_WIDTH:   csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT:  csr_prdata = CSR_DATA_W'(height_ff);
         default:     csr_prdata = '0;
      endcase
   end

   logic wdiv_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ktop_ff     <= RST_KTOP;
         kmid_ff     <= RST_KMID;
         kbot_ff     <= RST_KBOT;
         divisor_ff  <= RST_DIVISOR;
         maxv_ff     <= RST_MAXVAL;
         width_ff    <= RST_WIDTH;
         height_ff   <= RST_HEIGHT;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_KTOP:    ktop_ff    <= csr_pwdata[KREG_W-1:0];
            REG_KMID:    kmid_ff    <= csr_pwdata[KREG_W-1:0];
            REG_KBOT:    kbot_ff    <= csr_pwdata[KREG_W-1:0];
            REG_DIVISOR: divisor_ff <= csr_pwdata[DIV_W-1:0];
            REG_MAXVAL:  maxv_ff    <= csr_pwdata[PIX_W-1:0];
            REG_WIDTH:   width_ff   <= csr_pwdata[WCFG_W-1:0];
            REG_HEIGHT:  height_ff  <= csr_pwdata[HCFG_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped frame size and its product
   logic [WC_W-1:0]  wc;
   logic [HC_W-1:0]  hc;
   logic [HW_W-1:0]  hw_ff;
   logic [DIV_W-1:0] div_eff;

   always_comb begin
      int unsigned wv, hv;
      wv = 32'(width_ff);
      hv = 32'(height_ff);
      if (wv < 32'd3) wv = 32'd3;
      if (wv > 32'(MAX_WIDTH)) wv = 32'(MAX_WIDTH);
      if (hv < 32'd3) hv = 32'd3;
      if (hv > 32'(MAX_HEIGHT)) hv = 32'(MAX_HEIGHT);
      wc = WC_W'(wv);
      hc = HC_W'(hv);
      div_eff = (divisor_ff == '0) ? DIV_W'(1) : divisor_ff;
   end

   always_ff @(posedge clock) begin
      hw_ff <= HW_W'(wc) * HW_W'(hc);
   end

   // frame state
   top_state_type     state_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WC_W-1:0]   ocol_ff;
   logic [CNT_W-1:0]  orow_ff;
   logic              tail_ff;
   logic [PIX3_W-1:0] pix_ff;
   logic [PIX3_W-1:0] win_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic              border_ff, last_ff;
   logic              lane_start_ff;

   // line stores
   logic [PIX3_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX3_W-1:0] lower_mem [MAX_WIDTH];
   logic [PIX3_W-1:0] up_rd_ff, lo_rd_ff;

   // width-change divide
   logic [CNT_W-1:0]  wd_dvd_ff, wd_quo_ff;
   logic [WC_W:0]     wd_rem_ff, wd_rem_sh;
   logic [WSTP_W-1:0] wd_step_ff;
   logic              wd_bit;

   // output register
   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic              rsp_border_ff, rsp_last_ff;

   logic              req_acc;
   logic              out_free;

   assign req_ch.ready = (state_ff == ST_IDLE) && !wdiv_req_ff;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      wd_rem_sh = {wd_rem_ff[WC_W-1:0], wd_dvd_ff[CNT_W-1]};
      wd_bit    = (wd_rem_sh >= {1'b0, wc});
   end

   // step decisions for one beat
   logic             emit, at_end, border, tail_in, last;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;

   always_comb begin
      emit   = tail_ff || (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
      at_end = (32'(col_ff) + 32'd1) >= 32'(wc);
      col_in = at_end ? '0 : col_ff + COL_W'(1);
      row_in  = row_ff;
      tail_in = tail_ff;
      if (at_end && !tail_ff) begin
         if ((32'(row_ff) + 32'd1) >= 32'(hc)) begin
            tail_in = 1'b1;
            row_in  = '0;
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
      border = (orow_ff == '0) || ((32'(orow_ff) + 32'd1) >= 32'(hc))
            || (ocol_ff == '0) || ((32'(ocol_ff) + 32'd1) == 32'(wc));
      // a real pixel that completes the count ends the frame only if it is zero
      last   = tail_in && ((32'(cnt_ff) + 32'd1) >= 32'(hw_ff)) && (pix_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         up_rd_ff <= upper_mem[col_ff];
         lo_rd_ff <= lower_mem[col_ff];
      end
      if (state_ff == ST_WIN) begin
         upper_mem[col_ff] <= lo_rd_ff;
         lower_mem[col_ff] <= pix_ff;
      end
   end

   // lanes
   lane_cmd_type  lane_cmd;
   lane_stat_type lane_stat [3];

   assign lane_cmd.start     = lane_start_ff;
   assign lane_cmd.divisor   = div_eff;
   assign lane_cmd.max_value = maxv_ff;

   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      logic [KTAPS-1:0][PIX_W-1:0]     pix_taps;
      logic [KTAPS-1:0][COEF_BITS-1:0] coef_taps;

      always_comb begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
               pix_taps[r*KERNEL_SIZE+c] = win_ff[r][c][ch*PIX_W +: PIX_W];
            end
         end
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            coef_taps[c]                 = coef_at(ktop_ff, c);
            coef_taps[KERNEL_SIZE+c]     = coef_at(kmid_ff, c);
            coef_taps[2*KERNEL_SIZE+c]   = coef_at(kbot_ff, c);
         end
      end

      rgbc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cmd       (lane_cmd),
         .pix_taps  (pix_taps),
         .coef_taps (coef_taps),
         .stat      (lane_stat[ch])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         cnt_ff        <= '0;
         ocol_ff       <= '0;
         orow_ff       <= '0;
         tail_ff       <= 1'b0;
         lane_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wdiv_req_ff   <= 1'b0;
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         lane_start_ff <= 1'b0;
         if (csr_wr && csr_idx == REG_WIDTH) begin
            wdiv_req_ff <= 1'b1;
         end
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (wdiv_req_ff) begin
                  wdiv_req_ff <= 1'b0;
                  wd_dvd_ff   <= cnt_ff;
                  wd_quo_ff   <= '0;
                  wd_rem_ff   <= '0;
                  wd_step_ff  <= WSTP_W'(CNT_W);
                  state_ff    <= ST_WDIV;
               end else if (req_acc) begin
                  // a drain beat before the frame is in does nothing
                  if (tail_ff || !req_ch.action) begin
                     pix_ff   <= tail_ff ? '0
                               : {req_ch.in_blue, req_ch.in_green, req_ch.in_red};
                     state_ff <= ST_WIN;
                  end
               end
            end
            ST_WIN: begin
               for (int r = 0; r < KERNEL_SIZE; r++) begin
                  win_ff[r][0] <= win_ff[r][1];
                  win_ff[r][1] <= win_ff[r][2];
               end
               win_ff[0][2] <= up_rd_ff;
               win_ff[1][2] <= lo_rd_ff;
               win_ff[2][2] <= pix_ff;
               col_ff  <= col_in;
               row_ff  <= row_in;
               tail_ff <= tail_in;
               if (!emit) begin
                  state_ff <= ST_IDLE;
               end else begin
                  border_ff <= border;
                  last_ff   <= last;
                  if (last) begin
                     col_ff  <= '0;
                     row_ff  <= '0;
                     cnt_ff  <= '0;
                     ocol_ff <= '0;
                     orow_ff <= '0;
                     tail_ff <= 1'b0;
                  end else begin
                     cnt_ff <= cnt_ff + CNT_W'(1);
                     if ((32'(ocol_ff) + 32'd1) >= 32'(wc)) begin
                        ocol_ff <= '0;
                        orow_ff <= orow_ff + CNT_W'(1);
                     end else begin
                        ocol_ff <= ocol_ff + WC_W'(1);
                     end
                  end
                  if (border) begin
                     state_ff <= ST_OUT;
                  end else begin
                     lane_start_ff <= 1'b1;
                     state_ff      <= ST_CALC;
                  end
               end
            end
            ST_CALC: begin
               if (lane_stat[0].done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_border_ff <= border_ff;
                  rsp_last_ff   <= last_ff;
                  if (border_ff) begin
                     {rsp_b_ff, rsp_g_ff, rsp_r_ff} <= win_ff[1][1];
                  end else begin
                     rsp_r_ff <= lane_stat[0].result;
                     rsp_g_ff <= lane_stat[1].result;
                     rsp_b_ff <= lane_stat[2].result;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_WDIV: begin
               wd_rem_ff  <= wd_bit ? (wd_rem_sh - {1'b0, wc}) : wd_rem_sh;
               wd_quo_ff  <= {wd_quo_ff[CNT_W-2:0], wd_bit};
               wd_dvd_ff  <= {wd_dvd_ff[CNT_W-2:0], 1'b0};
               wd_step_ff <= wd_step_ff - WSTP_W'(1);
               if (wd_step_ff == '0) begin
                  orow_ff  <= wd_quo_ff;
                  ocol_ff  <= wd_rem_ff[WC_W-1:0];
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_red    = rsp_r_ff;
   assign rsp_ch.out_green  = rsp_g_ff;
   assign rsp_ch.out_blue   = rsp_b_ff;
   assign rsp_ch.is_border  = rsp_border_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

endmodule

### tb/sv/tb_rgb_conv3x3_clamp_filter_top.sv
// Self-checking bench for the 3x3 RGB convolution filter: raster frames with
// random content, drain beats and register changes, checked against a window model.
// Depends on rgbc_pkg, rgbc_req_if, rgbc_rsp_if and the filter RTL.
module tb_rgb_conv3x3_clamp_filter_top;
   import rgbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW        = DEF_MAX_WIDTH;
   localparam int MAXH        = DEF_MAX_HEIGHT;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int SETTLE      = 64;

   typedef struct packed {
      logic             drain;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pix_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             border;
      logic             last;
   } out_pix_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rgbc_req_if req_ch ();
   rgbc_rsp_if rsp_ch ();

   rgb_conv3x3_clamp_filter_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------- filter model state ----------------
   logic [KREG_W-1:0] k_row [3];
   logic [DIV_W-1:0]  divisor_cfg;
   logic [PIX_W-1:0]  max_cfg;
   logic [WCFG_W-1:0] width_cfg;
   logic [HCFG_W-1:0] height_cfg;

   logic [PIX3_W-1:0] upper_line [MAXW];
   logic [PIX3_W-1:0] lower_line [MAXW];
   logic [PIX3_W-1:0] win [3][3];
   int  in_col, in_row, out_count;
   bit  in_tail;

   pix_beat_type beat_q [$];
   out_pix_type  out_pix_q [$];

   int  fails, pix_beats, frames, out_seen, filtered_seen, settings;
   int  cycles;
   bit  quiet, hold_req, hold_taken;
   int  gap_left, stall_left, hold_left;

   function automatic int eff_width();
      return (width_cfg < 3) ? 3 : (width_cfg > MAXW) ? MAXW : int'(width_cfg);
   endfunction

   function automatic int eff_height();
      return (height_cfg < 3) ? 3 : (height_cfg > MAXH) ? MAXH : int'(height_cfg);
   endfunction

   function automatic logic [PIX_W-1:0] conv_channel(input int sh);
      int sum, cf, px, d;
      sum = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cf = $signed(k_row[r][c*COEF_BITS +: COEF_BITS]);
            px = int'(win[r][c][sh +: PIX_W]);
            sum += px * cf;
         end
      end
      d = (divisor_cfg == 0) ? 1 : int'(divisor_cfg);
      sum = sum / d;
      if (sum > 255) return max_cfg;
      if (sum < 0) return '0;
      return PIX_W'(sum);
   endfunction

   task automatic conv_window_step(input logic drain, input logic [PIX3_W-1:0] px);
      int w, h, col, orow, ocol;
      logic [PIX3_W-1:0] pix, up, lo, ctr;
      bit emit, brd, last;
      out_pix_type o;
      w = eff_width();
      h = eff_height();
      if (!in_tail && drain) return;
      pix = in_tail ? '0 : px;
      col = (in_col >= MAXW) ? 0 : in_col;
      up = upper_line[col];
      lo = lower_line[col];
      upper_line[col] = lo;
      lower_line[col] = pix;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = pix;
      emit = in_tail || in_row >= 2 || (in_row == 1 && col >= 1);
      if (col + 1 >= w) begin
         in_col = 0;
         if (!in_tail) begin
            if (in_row + 1 >= h) begin
               in_tail = 1'b1;
               in_row = 0;
            end else begin
               in_row++;
            end
         end
      end else begin
         in_col = col + 1;
      end
      if (!emit) return;
      orow = out_count / w;
      ocol = out_count % w;
      brd = orow == 0 || orow >= h - 1 || ocol == 0 || ocol == w - 1;
      ctr = win[1][1];
      if (brd) begin
         o.red   = ctr[7:0];
         o.green = ctr[15:8];
         o.blue  = ctr[23:16];
      end else begin
         o.red   = conv_channel(0);
         o.green = conv_channel(8);
         o.blue  = conv_channel(16);
      end
      o.border = brd;
      // tail ticks carry zero; a real pixel that reaches the count ends the
      // frame only when it is zero
      last = in_tail && (out_count + 1 >= h * w) && (pix == '0);
      if (last) begin
         in_col = 0;
         in_row = 0;
         out_count = 0;
         in_tail = 1'b0;
      end else begin
         out_count++;
      end
      o.last = last;
      out_pix_q.push_back(o);
   endtask

   // ---------------- pixel driver ----------------
   always @(posedge clock) begin : pixel_driver
      pix_beat_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
         end else if (beat_q.size() > 0) begin
            nxt = beat_q.pop_front();
            req_ch.valid    <= 1'b1;
            req_ch.action   <= nxt.drain;
            req_ch.in_red   <= nxt.red;
            req_ch.in_green <= nxt.green;
            req_ch.in_blue  <= nxt.blue;
            if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 10);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : pixel_accept
      if (!reset && req_ch.valid && req_ch.ready)
         conv_window_step(req_ch.action, {req_ch.in_blue, req_ch.in_green, req_ch.in_red});
   end

   // ---------------- result sink and checker ----------------
   always @(posedge clock) begin : result_sink
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
         hold_left    <= 0;
         hold_taken   <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken   <= 1'b1;
         hold_left    <= 400;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left   <= $urandom_range(0, 9);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      out_pix_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         out_seen++;
         if (out_pix_q.size() == 0) begin
            $error("result beat with nothing pending");
            fails++;
         end else begin
            e = out_pix_q.pop_front();
            if (!e.border) filtered_seen++;
            if (rsp_ch.out_red !== e.red) begin
               $error("out_red: expected %0d, got %0d", e.red, rsp_ch.out_red);
               fails++;
            end
            if (rsp_ch.out_green !== e.green) begin
               $error("out_green: expected %0d, got %0d", e.green, rsp_ch.out_green);
               fails++;
            end
            if (rsp_ch.out_blue !== e.blue) begin
               $error("out_blue: expected %0d, got %0d", e.blue, rsp_ch.out_blue);
               fails++;
            end
            if (rsp_ch.is_border !== e.border) begin
               $error("is_border: expected %0d, got %0d", e.border, rsp_ch.is_border);
               fails++;
            end
            if (rsp_ch.frame_last !== e.last) begin
               $error("frame_last: expected %0d, got %0d", e.last, rsp_ch.frame_last);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL rgb_conv3x3_clamp_filter_top");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic [PIX_W-1:0] rand_chan();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic push_pixel(input logic [PIX_W-1:0] r, g, b);
      pix_beat_type p;
      p.drain = 1'b0;
      p.red   = r;
      p.green = g;
      p.blue  = b;
      beat_q.push_back(p);
      pix_beats++;
   endtask

   task automatic push_drain();
      pix_beat_type p;
      p.drain = 1'b1;
      p.red   = rand_chan();
      p.green = rand_chan();
      p.blue  = rand_chan();
      beat_q.push_back(p);
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (beat_q.size() > 0 || req_ch.valid || out_pix_q.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] v);
      case (idx)
         REG_KTOP:    k_row[0]    = v[KREG_W-1:0];
         REG_KMID:    k_row[1]    = v[KREG_W-1:0];
         REG_KBOT:    k_row[2]    = v[KREG_W-1:0];
         REG_DIVISOR: divisor_cfg = v[DIV_W-1:0];
         REG_MAXVAL:  max_cfg     = v[PIX_W-1:0];
         REG_WIDTH:   width_cfg   = v[WCFG_W-1:0];
         REG_HEIGHT:  height_cfg  = v[HCFG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings++;
   endtask

   // pixels of a frame, with the odd premature drain mixed in (ignored by the block)
   task automatic send_pixels(input int n, input bit noise);
      for (int i = 0; i < n; i++) begin
         if (noise && $urandom_range(0, 15) == 0) push_drain();
         push_pixel(rand_chan(), rand_chan(), rand_chan());
      end
   endtask

   // flush of width+1 or width+2 beats; some carry a pixel that the block discards
   task automatic send_tail();
      for (int i = 0; i <= eff_width(); i++) begin
         if ($urandom_range(0, 3) == 0) push_pixel(rand_chan(), rand_chan(), rand_chan());
         else push_drain();
      end
      if ($urandom_range(0, 2) == 0) push_drain();
      frames++;
   endtask

   function automatic logic [KREG_W-1:0] rand_kernel();
      case ($urandom_range(0, 4))
         0:       return 24'h7F7F7F;
         1:       return 24'h808080;
         2:       return 24'h010101;
         default: return KREG_W'($urandom);
      endcase
   endfunction

   task automatic shuffle_config();
      logic [CSR_DATA_W-1:0] v;
      if ($urandom_range(0, 1)) csr_write(REG_KTOP, {8'($urandom_range(0, 255)), rand_kernel()});
      if ($urandom_range(0, 1)) csr_write(REG_KMID, {8'($urandom_range(0, 255)), rand_kernel()});
      if ($urandom_range(0, 1)) csr_write(REG_KBOT, {8'($urandom_range(0, 255)), rand_kernel()});
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 4))
            0:       v = 0;
            1:       v = 1023;
            2:       v = $urandom;
            default: v = $urandom_range(1, 64);
         endcase
         csr_write(REG_DIVISOR, v);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 2))
            0:       v = 0;
            1:       v = 255;
            default: v = $urandom;
         endcase
         csr_write(REG_MAXVAL, v);
      end
      if ($urandom_range(0, 1)) csr_write(REG_WIDTH, $urandom_range(0, 8));
      if ($urandom_range(0, 1)) csr_write(REG_HEIGHT, $urandom_range(0, 6));
   endtask

   task automatic random_frame();
      int w, h, part;
      w = eff_width();
      h = eff_height();
      if ($urandom_range(0, 4) == 0) begin
         // change kernel and grow or keep the height with the frame partly received
         part = $urandom_range(w + 2, w * h - 1);
         send_pixels(part, 1'b1);
         wait_idle();
         csr_write(REG_KMID, rand_kernel());
         csr_write(REG_HEIGHT, h + $urandom_range(0, 2));
         send_pixels(eff_height() * w - part, 1'b1);
      end else begin
         send_pixels(w * h, 1'b1);
      end
      send_tail();
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.action  = 1'b0;
      req_ch.in_red  = '0;
      req_ch.in_green = '0;
      req_ch.in_blue = '0;
      rsp_ch.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      cycles = 0;
      fails = 0;
      quiet = 1'b0;
      hold_req = 1'b0;
      k_row[0] = RST_KTOP;
      k_row[1] = RST_KMID;
      k_row[2] = RST_KBOT;
      divisor_cfg = RST_DIVISOR;
      max_cfg = RST_MAXVAL;
      width_cfg = RST_WIDTH;
      height_cfg = RST_HEIGHT;
      for (int i = 0; i < MAXW; i++) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) win[r][c] = '0;
      in_col = 0;
      in_row = 0;
      out_count = 0;
      in_tail = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // saturating kernel, zero divisor, max value of zero on a 3x3 frame
      csr_write(REG_WIDTH, 3);
      csr_write(REG_HEIGHT, 3);
      csr_write(REG_KTOP, 32'h007F7F7F);
      csr_write(REG_KMID, 32'hFF7F7F7F);
      csr_write(REG_KBOT, 32'h007F7F7F);
      csr_write(REG_DIVISOR, 0);
      csr_write(REG_MAXVAL, 0);
      push_drain();
      push_pixel(8'h00, 8'h00, 8'h00);
      for (int i = 1; i < 9; i++) push_pixel(8'hFF, 8'hFF, 8'hFF);
      send_tail();
      wait_idle();
      // most negative kernel drives every channel below zero
      csr_write(REG_KTOP, 32'h00808080);
      csr_write(REG_KMID, 32'h00808080);
      csr_write(REG_KBOT, 32'h00808080);
      csr_write(REG_DIVISOR, 1);
      csr_write(REG_MAXVAL, 255);
      for (int i = 0; i < 9; i++) push_pixel(8'hFF, 8'h80, 8'h01);
      send_tail();
      wait_idle();

      // random frames; the receiver holds off for a while during the first one
      hold_req = 1'b1;
      while (pix_beats < 250) begin
         shuffle_config();
         random_frame();
      end

      // closing stretch at full rate on both sides
      quiet = 1'b1;
      repeat (3) begin
         shuffle_config();
         random_frame();
      end

      $display("Sent %0d pixel beats in %0d frames under %0d register writes;",
               pix_beats, frames, settings);
      $display("checked %0d result pixels, %0d of them filtered.", out_seen, filtered_seen);
      if (fails == 0) begin
         $display("PASS rgb_conv3x3_clamp_filter_top");
      end else begin
         $display("FAIL rgb_conv3x3_clamp_filter_top");
      end
      $finish;
   end

endmodule

### rgb_conv3x3_clamp_filter_top.f
rtl/rgbc_pkg.sv
rtl/rgbc_req_if.sv
rtl/rgbc_rsp_if.sv
rtl/rgbc_lane.sv
rtl/rgb_conv3x3_clamp_filter_top.sv
tb/sv/tb_rgb_conv3x3_clamp_filter_top.sv
